[rtl/plss_pkg.sv]
// shared types and constants for the piecewise-linear sensor scaler
`default_nettype none

package plss_pkg;

    // field widths
    localparam int X_W    = 13;
    localparam int Y_W    = 16;
    localparam int S_W    = 12;
    localparam int IDX_W  = 7;
    localparam int CFG_W  = 8;

    // interpolation arithmetic widths
    localparam int PROD_W = 30;
    localparam int SUM_W  = PROD_W + 1;
    localparam int MAG_W  = 28;
    localparam int DIVC_W = 5;

    // points in use after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 8'd2;

    // request types
    typedef enum logic {
        REQ_CONVERT = 1'b0,
        REQ_LOAD    = 1'b1
    } req_type_t;

    // input request payload
    typedef struct packed {
        req_type_t               req_type;
        logic [IDX_W-1:0]        point_index;
        logic [X_W-1:0]          point_x;
        logic signed [Y_W-1:0]   point_y;
        logic [S_W-1:0]          sample;
    } in_t;

    // result payload
    typedef struct packed {
        logic signed [Y_W-1:0]   scaled_value;
        logic                    in_range;
    } out_t;

endpackage

`default_nettype wire

[rtl/plss_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module plss_ram #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/piecewise_linear_sensor_scaler.sv]
// a load request is written in the cycle it is accepted, one load per cycle while no convert is in flight
// a convert scans the n points in use one breakpoint per cycle through the ram read
//   port, then takes a multiply step, a sum step and a bit-serial restoring divide of
//   the 28-bit magnitude; a sample out of range skips the arithmetic
// one convert in flight; no request is taken until its result is in the output register
// reset clears control state and sets points_in_use to 2; table contents are undefined
`default_nettype none

module piecewise_linear_sensor_scaler
    import plss_pkg::*;
#(
    parameter int MAX_POINTS = 128
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_t              s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_t                  m_data,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int MEM_W = X_W + Y_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [CFG_W-1:0]        points_in_use_reg;
    logic [CNT_W-1:0]        n_eff_reg;
    logic [CNT_W-1:0]        issue_reg;
    logic [CNT_W-1:0]        arr_reg;
    logic                    pend_reg;
    logic [S_W-1:0]          sample_reg;
    logic [X_W-1:0]          x0_reg;
    logic [X_W-1:0]          x1_reg;
    logic signed [Y_W-1:0]   y0_reg;
    logic signed [Y_W-1:0]   y1_reg;
    logic [X_W-1:0]          dx_reg;
    logic signed [PROD_W-1:0] p0_reg;
    logic signed [PROD_W-1:0] p1_reg;
    logic                    neg_reg;
    logic [MAG_W-1:0]        num_reg;
    logic [X_W-1:0]          rem_reg;
    logic [DIVC_W-1:0]       div_cnt_reg;
    logic signed [Y_W-1:0]   res_value_reg;
    logic                    res_in_range_reg;
    logic                    m_valid_reg;
    out_t                    m_data_reg;

    // ram ports
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [31:0]             idx_ext;
    logic                    rd_en;
    logic [MEM_W-1:0]        rd_data;
    logic [X_W-1:0]          cur_x;
    logic signed [Y_W-1:0]   cur_y;

    // combinational helpers
    logic                    accept;
    logic [CMP_W-1:0]        cfg_ext;
    logic [CMP_W-1:0]        n_sel;
    logic [CNT_W-1:0]        n_eff_next;
    logic [X_W-1:0]          s_ext;
    logic                    seg_hit;
    logic [X_W-1:0]          dx_next;
    logic [X_W-1:0]          ds_next;
    logic signed [PROD_W-1:0] y0_ext;
    logic signed [PROD_W-1:0] dx_ext;
    logic signed [PROD_W-1:0] ds_ext;
    logic signed [PROD_W-1:0] dy_ext;
    logic signed [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0]        abs_next;
    logic [X_W:0]            trial;
    logic                    trial_ge;

    assign s_ready = aresetn && (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // effective point count, clamped to the table depth
    assign cfg_ext    = CMP_W'(points_in_use_reg);
    assign n_sel      = (cfg_ext > CMP_W'(MAX_POINTS)) ? CMP_W'(MAX_POINTS) : cfg_ext;
    assign n_eff_next = n_sel[CNT_W-1:0];

    // breakpoint write on an accepted load request
    assign idx_ext = 32'(s_data.point_index);
    assign wr_en   = accept && (s_data.req_type == REQ_LOAD)
                     && (idx_ext < 32'(MAX_POINTS));
    assign wr_addr = idx_ext[AW-1:0];

    // sequential scan reads
    assign rd_en = (state_reg == ST_SCAN) && (issue_reg < n_eff_reg);

    plss_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({s_data.point_x, s_data.point_y}),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign cur_x = rd_data[MEM_W-1:Y_W];
    assign cur_y = rd_data[Y_W-1:0];

    // segment test between the previous and the arriving breakpoint
    assign s_ext   = X_W'(sample_reg);
    assign seg_hit = (arr_reg != '0) && (x0_reg <= s_ext) && (s_ext < cur_x);

    // multiplier operands
    assign dx_next = x1_reg - x0_reg;
    assign ds_next = s_ext - x0_reg;
    assign y0_ext  = PROD_W'(y0_reg);
    assign dx_ext  = PROD_W'(dx_next);
    assign ds_ext  = PROD_W'(ds_next);
    assign dy_ext  = PROD_W'(y1_reg) - PROD_W'(y0_reg);

    // numerator and its magnitude
    assign sum_next = SUM_W'(p0_reg) + SUM_W'(p1_reg);
    assign abs_next = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);

    // one restoring divide step
    assign trial    = {rem_reg, num_reg[MAG_W-1]};
    assign trial_ge = (trial >= {1'b0, dx_reg});

    // control, datapath and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            points_in_use_reg <= CFG_RESET;
            pend_reg          <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                points_in_use_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept && (s_data.req_type == REQ_CONVERT)) begin
                        sample_reg <= s_data.sample;
                        n_eff_reg  <= n_eff_next;
                        issue_reg  <= '0;
                        arr_reg    <= '0;
                        pend_reg   <= 1'b0;
                        if (n_eff_next < CNT_W'(2)) begin
                            res_value_reg    <= '0;
                            res_in_range_reg <= 1'b0;
                            state_reg        <= ST_DONE;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end

                ST_SCAN: begin
                    if (rd_en) begin
                        issue_reg <= issue_reg + 1'b1;
                    end
                    pend_reg <= rd_en;
                    if (pend_reg) begin
                        arr_reg <= arr_reg + 1'b1;
                        if (seg_hit) begin
                            x1_reg    <= cur_x;
                            y1_reg    <= cur_y;
                            state_reg <= ST_MUL;
                        end else if (arr_reg == n_eff_reg - 1'b1) begin
                            res_value_reg    <= '0;
                            res_in_range_reg <= 1'b0;
                            state_reg        <= ST_DONE;
                        end else begin
                            x0_reg <= cur_x;
                            y0_reg <= cur_y;
                        end
                    end
                end

                ST_MUL: begin
                    dx_reg    <= dx_next;
                    p0_reg    <= y0_ext * dx_ext;
                    p1_reg    <= ds_ext * dy_ext;
                    state_reg <= ST_SUM;
                end

                ST_SUM: begin
                    neg_reg     <= sum_next[SUM_W-1];
                    num_reg     <= abs_next[MAG_W-1:0];
                    rem_reg     <= '0;
                    div_cnt_reg <= DIVC_W'(MAG_W - 1);
                    state_reg   <= ST_DIV;
                end

                ST_DIV: begin
                    rem_reg <= trial_ge ? X_W'(trial - {1'b0, dx_reg}) : trial[X_W-1:0];
                    num_reg <= {num_reg[MAG_W-2:0], trial_ge};
                    if (div_cnt_reg == '0) begin
                        state_reg <= ST_DONE;
                    end else begin
                        div_cnt_reg <= div_cnt_reg - 1'b1;
                    end
                end

                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg             <= 1'b1;
                        m_data_reg.scaled_value <= res_value_reg;
                        m_data_reg.in_range     <= res_in_range_reg;
                        state_reg               <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // signed quotient lands in the result register as the divide finishes
            if (state_reg == ST_DIV && div_cnt_reg == '0) begin
                res_in_range_reg <= 1'b1;
                res_value_reg    <= neg_reg
                    ? $signed(-{num_reg[Y_W-2:0], trial_ge})
                    : $signed({num_reg[Y_W-2:0], trial_ge});
            end
        end
    end

endmodule

`default_nettype wire

[tb/plss_checker.sv]
// request/result checker with interpolation predictor for the sensor scaler
`default_nettype none

module plss_checker
    import plss_pkg::*;
#(
    parameter int MAX_POINTS = 128
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_ready,
    input  wire in_t              s_data,
    input  wire logic             m_valid,
    input  wire logic             m_ready,
    input  wire out_t             m_data,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    output int                    pending,
    output int                    errors
);
    timeunit 1ns;
    timeprecision 1ps;

    // calibration table and register as the block should hold them
    logic [X_W-1:0]        cal_x [MAX_POINTS];
    logic signed [Y_W-1:0] cal_y [MAX_POINTS];
    int unsigned           cal_points;
    out_t                  scaled_q [$];
    int                    mismatch_count = 0;

    // one line per mismatch, counted
    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // exact interpolation, truncated toward zero; first matching segment wins
    function automatic out_t interpolate(input logic [S_W-1:0] smp);
        out_t        r;
        int unsigned lim;
        int          i;
        bit          found;
        longint      x0, x1, dx, ds, y0, y1, q;
        r     = '0;
        found = 1'b0;
        lim   = (cal_points > MAX_POINTS) ? MAX_POINTS : cal_points;
        for (i = 0; i + 1 < lim; i++) begin
            x0 = longint'(cal_x[i]);
            x1 = longint'(cal_x[i + 1]);
            if (!found && longint'(smp) >= x0 && longint'(smp) < x1) begin
                dx = x1 - x0;
                ds = longint'(smp) - x0;
                y0 = longint'(cal_y[i]);
                y1 = longint'(cal_y[i + 1]);
                q  = (y0 * dx + ds * (y1 - y0)) / dx;
                r.scaled_value = q[Y_W-1:0];
                r.in_range     = 1'b1;
                found          = 1'b1;
            end
        end
        return r;
    endfunction

    // watch both channels and the register port at every edge
    always @(posedge aclk) begin : watch
        out_t want;
        out_t got;
        if (!aresetn) begin
            cal_points = CFG_RESET;
            for (int k = 0; k < MAX_POINTS; k++) begin
                cal_x[k] = '0;
                cal_y[k] = '0;
            end
            scaled_q.delete();
        end else begin
            if (cfg_wr_en) begin
                cal_points = cfg_wr_data;
            end
            // result side: compare with the oldest outstanding convert
            if (m_valid && m_ready) begin
                got = m_data;
                if (scaled_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d/%0b with no convert outstanding",
                                              got.scaled_value, got.in_range));
                end else begin
                    want = scaled_q.pop_front();
                    if (got.scaled_value !== want.scaled_value) begin
                        report_mismatch($sformatf("scaled_value %0d, predicted %0d",
                                                  got.scaled_value, want.scaled_value));
                    end
                    if (got.in_range !== want.in_range) begin
                        report_mismatch($sformatf("in_range %0b, predicted %0b",
                                                  got.in_range, want.in_range));
                    end
                end
            end
            // request side: loads update the table, converts queue a prediction
            if (s_valid && s_ready) begin
                if (s_data.req_type == REQ_LOAD) begin
                    if (s_data.point_index < MAX_POINTS) begin
                        cal_x[s_data.point_index] = s_data.point_x;
                        cal_y[s_data.point_index] = s_data.point_y;
                    end
                end else begin
                    scaled_q.push_back(interpolate(s_data.sample));
                end
            end
        end
        pending <= scaled_q.size();
        errors  <= mismatch_count;
    end

endmodule

`default_nettype wire

[tb/testbench.sv]
// stimulus, clock, reset and verdict for the piecewise-linear sensor scaler
`default_nettype none

module testbench
    import plss_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_POINTS    = 128;
    localparam int RANDOM_ITEMS  = 290;
    localparam int SETTLE_CYCLES = MAX_POINTS + 80;
    localparam int CYCLE_LIMIT   = 1_000_000;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    in_t              s_data      = '0;
    logic             m_ready     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_ready;
    logic             m_valid;
    out_t             m_data;
    int               pending;
    int               errors;

    int src_idle_pct  = 14;
    int sink_idle_pct = 71;
    int items_sent    = 0;
    int cycles        = 0;
    int points_cfg    = 2;
    int table_x [MAX_POINTS];

    piecewise_linear_sensor_scaler #(
        .MAX_POINTS(MAX_POINTS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    plss_checker #(
        .MAX_POINTS(MAX_POINTS)
    ) scaler_check (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .pending(pending),
        .errors(errors)
    );

    // 2 ns clock
    initial begin
        forever #1 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // present one request, holding valid until it is taken
    task automatic send_req(input in_t item);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // load request; the unused sample field carries noise
    task automatic load_point(input int idx, input int x, input int y);
        in_t item;
        item.req_type    = REQ_LOAD;
        item.point_index = IDX_W'(idx);
        item.point_x     = X_W'(x);
        item.point_y     = Y_W'(y);
        item.sample      = S_W'($urandom);
        if (idx < MAX_POINTS) begin
            table_x[idx] = x;
        end
        send_req(item);
    endtask

    // convert request; the unused breakpoint fields carry noise
    task automatic convert(input int smp);
        in_t item;
        item.req_type    = REQ_CONVERT;
        item.point_index = IDX_W'($urandom);
        item.point_x     = X_W'($urandom);
        item.point_y     = Y_W'($urandom);
        item.sample      = S_W'(smp);
        send_req(item);
    endtask

    // drain outstanding converts, then let any in-flight work finish
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_points(input int n);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(n);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        points_cfg  = n;
    endtask

    function automatic int random_y();
        case ($urandom_range(7))
            0:       return -32768;
            1:       return 32767;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // strictly increasing table over the points in use, optionally spoilt by one slot
    task automatic load_table(input int n, input bit spoil);
        int span, stride, x, k;
        span   = (n < 2) ? 2 : ((n > MAX_POINTS) ? MAX_POINTS : n);
        stride = 4096 / span;
        x      = ($urandom_range(2) == 0) ? 0 : $urandom_range(0, stride - 1);
        for (k = 0; k < span; k++) begin
            if (k == span - 1 && $urandom_range(2) == 0) begin
                x = 4096;
            end
            load_point(k, x, random_y());
            x += $urandom_range(1, stride);
        end
        if (spoil) begin
            load_point($urandom_range(0, span - 1), $urandom_range(0, 4096), random_y());
        end
    endtask

    // samples mostly inside the table, some on or just below breakpoints
    function automatic int pick_sample();
        int n, lo, hi, k, v;
        n = (points_cfg > MAX_POINTS) ? MAX_POINTS : points_cfg;
        if (n < 2) begin
            return $urandom_range(0, 4095);
        end
        lo = table_x[0];
        hi = table_x[n - 1];
        if (lo > hi) begin
            v  = lo;
            lo = hi;
            hi = v;
        end
        if (hi > 4095) hi = 4095;
        if (lo > 4095) lo = 4095;
        k = $urandom_range(0, n - 1);
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: v = $urandom_range(lo, hi);
            6:                v = table_x[k];
            7:                v = table_x[k] - 1;
            default:          v = $urandom_range(0, 4095);
        endcase
        if (v > 4095) v = 4095;
        if (v < 0) v = 0;
        return v;
    endfunction

    initial begin : stimulus
        int base, sel, n, burst, j;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // every convert below reads only slots loaded before it
        set_points(2);

        // full-scale segment, both value extremes
        load_point(0, 0, -32768);
        load_point(1, 4096, 32767);
        convert(0);
        convert(4095);
        convert(2048);
        convert(1);
        // unit-width segment; sample on the last x is out of range
        load_point(1, 1, 32767);
        convert(0);
        convert(1);
        // zero-width segment never matches
        load_point(0, 100, 5);
        load_point(1, 100, -7);
        convert(100);
        // descending x leaves no segment
        load_point(0, 200, 0);
        load_point(1, 50, 0);
        convert(100);
        // steep fall at the top of the range
        load_point(0, 4094, 32767);
        load_point(1, 4095, -32768);
        convert(4094);
        convert(4095);
        convert(4093);
        // top x bits set
        load_point(0, 0, 32767);
        load_point(1, 8191, -32768);
        convert(4095);
        convert(0);

        // too few points: everything out of range
        set_points(0);
        convert(0);
        convert(4095);
        set_points(1);
        convert(2000);
        // above the table size acts as a full table
        set_points(255);
        load_table(MAX_POINTS, 1'b0);
        repeat (3) convert(pick_sample());
        set_points(MAX_POINTS);
        repeat (3) convert(pick_sample());

        // random phases: new point count, fresh table, a burst of converts
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            if (items_sent - base < RANDOM_ITEMS / 3) begin
                src_idle_pct  <= 14;
                sink_idle_pct <= 71;
            end else if (items_sent - base < 2 * RANDOM_ITEMS / 3) begin
                src_idle_pct  <= 71;
                sink_idle_pct <= 14;
            end else begin
                src_idle_pct  <= 0;
                sink_idle_pct <= 0;
            end
            sel = $urandom_range(99);
            if (sel < 4) begin
                n = $urandom_range(1) ? MAX_POINTS : 255;
            end else if (sel < 8) begin
                n = $urandom_range(0, 1);
            end else if (sel < 20) begin
                n = $urandom_range(17, 48);
            end else begin
                n = $urandom_range(2, 16);
            end
            set_points(n);
            load_table(n, $urandom_range(7) == 0);
            burst = $urandom_range(6, 18);
            for (j = 0; j < burst; j++) begin
                if ($urandom_range(15) == 0) begin
                    load_point($urandom_range(0, MAX_POINTS - 1), $urandom_range(0, 8191),
                               random_y());
                end else begin
                    convert(pick_sample());
                end
            end
        end

        settle();
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/plss_pkg.sv
rtl/plss_ram.sv
rtl/piecewise_linear_sensor_scaler.sv
tb/plss_checker.sv
tb/testbench.sv
